### hdl/pfbc_pkg.sv
`default_nettype none

package pfbc_pkg;

  localparam int VoltBits  = 14;
  localparam int CountBits = 4;
  localparam int ThrBits   = 14;
  localparam int MinBits   = 8;
  localparam int LimBits   = 4;
  localparam int PulseBits = 5;
  localparam int HalfBits  = 6;
  localparam int CfgDataBits = 14;
  localparam int CfgIdxBits  = 3;
  localparam int CmpBits   = (VoltBits > ThrBits) ? VoltBits : ThrBits;

  localparam logic [ThrBits-1:0]   ThrReset     = ThrBits'(9500);
  localparam logic [MinBits-1:0]   TrickleReset = MinBits'(5);
  localparam logic [MinBits-1:0]   EndReset     = MinBits'(55);
  localparam logic [LimBits-1:0]   HiLimReset   = LimBits'(3);
  localparam logic [LimBits-1:0]   LoLimReset   = LimBits'(7);
  localparam logic [PulseBits-1:0] PulseReset   = PulseBits'(2);
  localparam logic [HalfBits-1:0]  HalfReset    = HalfBits'(25);

  typedef enum logic [CfgIdxBits-1:0] {
    REG_FULL_THR   = 3'd0,
    REG_TRICKLE    = 3'd1,
    REG_END        = 3'd2,
    REG_HIGH_LIMIT = 3'd3,
    REG_LOW_LIMIT  = 3'd4,
    REG_PULSE_ON   = 3'd5,
    REG_HALF       = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_TRICKLE = 4'b0010,
    PH_FAST    = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_e;

  localparam logic [1:0] PhaseCodeIdle    = 2'd0;
  localparam logic [1:0] PhaseCodeTrickle = 2'd1;
  localparam logic [1:0] PhaseCodeFast    = 2'd2;
  localparam logic [1:0] PhaseCodeDone    = 2'd3;

  typedef struct packed {
    logic                action;
    logic [VoltBits-1:0] voltage_mv;
    logic [MinBits-1:0]  elapsed_minutes;
  } in_item_t;

  typedef struct packed {
    logic                charge_on;
    logic                green_led;
    logic                red_led;
    logic                battery_full;
    logic [1:0]          charge_phase;
    logic [VoltBits-1:0] last_voltage_mv;
  } out_item_t;

  // limits used by the voltage qualifier
  typedef struct packed {
    logic [ThrBits-1:0] thr;
    logic [LimBits-1:0] hi_lim;
    logic [LimBits-1:0] lo_lim;
  } lim_t;

  function automatic logic [1:0] phase_code(phase_e ph);
    logic [1:0] code;
    case (ph)
      PH_IDLE:    code = PhaseCodeIdle;
      PH_TRICKLE: code = PhaseCodeTrickle;
      PH_FAST:    code = PhaseCodeFast;
      PH_DONE:    code = PhaseCodeDone;
      default:    code = PhaseCodeIdle;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### hdl/pfbc_sample.sv
`default_nettype none

module pfbc_sample import pfbc_pkg::*; #(
  parameter int COUNT_BITS = CountBits
) (
  input  wire logic                  en_i,
  input  wire logic [VoltBits-1:0]   volt_i,
  input  wire lim_t                  lim_i,
  input  wire logic                  full_i,
  input  wire logic [COUNT_BITS-1:0] high_run_i,
  input  wire logic [COUNT_BITS-1:0] low_run_i,
  output logic                       full_o,
  output logic [COUNT_BITS-1:0]      high_run_o,
  output logic [COUNT_BITS-1:0]      low_run_o
);

  localparam int CW = (COUNT_BITS > LimBits) ? COUNT_BITS : LimBits;
  localparam logic [COUNT_BITS-1:0] RunMax = {COUNT_BITS{1'b1}};

  logic                  high;
  logic [COUNT_BITS-1:0] lo_next;
  logic [COUNT_BITS-1:0] hi_next;

  assign high = CmpBits'(volt_i) > CmpBits'(lim_i.thr);

  always_comb begin
    full_o     = full_i;
    high_run_o = high_run_i;
    low_run_o  = low_run_i;
    lo_next    = low_run_i;
    hi_next    = high_run_i;
    if (en_i) begin
      if (full_i) begin
        if (high) begin
          lo_next = '0;
        end else if (low_run_i != RunMax) begin
          lo_next = low_run_i + COUNT_BITS'(1);
        end
        low_run_o = lo_next;
        if (CW'(lo_next) > CW'(lim_i.lo_lim)) begin
          full_o    = 1'b0;
          low_run_o = '0;
        end
      end else begin
        if (high) begin
          low_run_o = '0;
          if (high_run_i != RunMax) begin
            hi_next = high_run_i + COUNT_BITS'(1);
          end
        end else begin
          hi_next = '0;
        end
        high_run_o = hi_next;
        if (CW'(hi_next) > CW'(lim_i.hi_lim)) begin
          full_o     = 1'b1;
          high_run_o = '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hdl/pulse_then_fast_battery_charger_unit.sv
// Pulse-then-fast battery charge sequencer, one input beat per 20 ms tick.
// Input channel (in_valid_i/in_ready_o, in_item_i): action 1 restarts the
// sequence in the pulse trickle phase, action 0 is one tick carrying the
// battery voltage and the elapsed minute count.
// Output channel (out_valid_o/out_ready_i, out_item_o): exactly one result
// beat per input beat, in order: charger drive, LEDs, full flag, phase and
// the last checked voltage.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): always
// ready; write only while no result is pending. Index 7 is ignored.
// The result of a beat is on the output register in the cycle after
// acceptance. Throughput: one beat per cycle unless the receiver stalls;
// the whole tick update is one pass of logic from the state registers into
// the result register. A stalled receiver holds the result register;
// in_ready_o then drops until that beat is taken, and a beat is accepted in
// the same cycle the held one leaves.
// Reset: phase idle, all counters and flags cleared, registers at their
// default values, no result pending.
`default_nettype none

module pulse_then_fast_battery_charger_unit import pfbc_pkg::*; #(
  parameter int COUNT_BITS = CountBits
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire in_item_t               in_item_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output out_item_t                   out_item_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i
);

  // configuration
  logic [ThrBits-1:0]   thr_q;
  logic [MinBits-1:0]   trickle_q;
  logic [MinBits-1:0]   end_q;
  logic [LimBits-1:0]   hi_lim_q;
  logic [LimBits-1:0]   lo_lim_q;
  logic [PulseBits-1:0] pulse_q;
  logic [HalfBits-1:0]  half_q;

  // sequencer state
  phase_e                phase_q, phase_d;
  logic [HalfBits-1:0]   tick_q, tick_d;
  logic                  sh_q, sh_d;
  logic                  blink_q, blink_d;
  logic                  green_q, green_d;
  logic                  charger_q, charger_d;
  logic                  full_q, full_d;
  logic [COUNT_BITS-1:0] high_run_q, high_run_d;
  logic [COUNT_BITS-1:0] low_run_q, low_run_d;
  logic [VoltBits-1:0]   last_q, last_d;

  logic      out_valid_q;
  out_item_t out_item_q;

  logic                  accept;
  logic                  tick_beat;
  logic [HalfBits-1:0]   hp;
  logic                  t0;
  logic                  trk_go;
  logic                  fast_entry;
  logic                  fast_active;
  logic [HalfBits-1:0]   ft_tick;
  logic                  ft_blink;
  logic                  ft_stop;
  logic [HalfBits:0]     ft_inc;
  logic                  ft_wrap;
  logic [HalfBits:0]     trk_inc;
  logic                  trk_wrap;
  logic                  samp_en;
  logic                  samp_full;
  logic [COUNT_BITS-1:0] samp_high_run;
  logic [COUNT_BITS-1:0] samp_low_run;
  lim_t                  lim;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign tick_beat   = accept && !in_item_i.action;

  assign hp = (half_q == '0) ? HalfBits'(1) : half_q;
  assign t0 = (tick_q == '0);
  assign trk_go = (in_item_i.elapsed_minutes < trickle_q) && !full_q;

  // fast charge entered from the start of a trickle period
  assign fast_entry  = tick_beat && (phase_q == PH_TRICKLE) && t0 && !sh_q && !trk_go;
  assign fast_active = fast_entry || (tick_beat && (phase_q == PH_FAST));
  assign ft_tick     = fast_entry ? '0 : tick_q;
  assign ft_blink    = fast_entry ? 1'b0 : blink_q;
  assign ft_stop     = (ft_tick == '0) &&
                       !((in_item_i.elapsed_minutes < end_q) && !full_q);
  assign ft_inc      = {1'b0, ft_tick} + (HalfBits+1)'(1);
  assign ft_wrap     = ft_inc >= {1'b0, hp};
  assign trk_inc     = {1'b0, tick_q} + (HalfBits+1)'(1);
  assign trk_wrap    = trk_inc >= {1'b0, hp};

  assign samp_en = (tick_beat && (phase_q == PH_TRICKLE) && t0 && (sh_q || trk_go)) ||
                   (fast_active && !ft_stop && ft_wrap);

  assign lim = '{thr: thr_q, hi_lim: hi_lim_q, lo_lim: lo_lim_q};

  pfbc_sample #(
    .COUNT_BITS(COUNT_BITS)
  ) u_sample (
    .en_i       (samp_en),
    .volt_i     (in_item_i.voltage_mv),
    .lim_i      (lim),
    .full_i     (full_q),
    .high_run_i (high_run_q),
    .low_run_i  (low_run_q),
    .full_o     (samp_full),
    .high_run_o (samp_high_run),
    .low_run_o  (samp_low_run)
  );

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    sh_d       = sh_q;
    blink_d    = blink_q;
    green_d    = green_q;
    charger_d  = charger_q;
    full_d     = samp_full;
    high_run_d = samp_high_run;
    low_run_d  = samp_low_run;
    last_d     = samp_en ? in_item_i.voltage_mv : last_q;
    if (accept && in_item_i.action) begin
      phase_d   = PH_TRICKLE;
      tick_d    = '0;
      sh_d      = 1'b0;
      full_d    = 1'b0;
      last_d    = '0;
      charger_d = 1'b0;
    end else if (fast_active) begin
      phase_d = PH_FAST;
      tick_d  = ft_tick;
      blink_d = ft_blink;
      if (ft_stop) begin
        phase_d   = PH_DONE;
        charger_d = 1'b0;
      end else begin
        if (ft_tick == '0) begin
          green_d = ft_blink;
          blink_d = !ft_blink;
        end
        charger_d = 1'b1;
        tick_d    = ft_wrap ? '0 : ft_inc[HalfBits-1:0];
      end
    end else if (tick_beat && (phase_q == PH_TRICKLE)) begin
      if (t0) begin
        green_d = !sh_q;
      end
      if (t0 && !sh_q && samp_full) begin
        // full at the first check of a period: fast charge ends at once
        phase_d   = PH_DONE;
        tick_d    = '0;
        blink_d   = 1'b0;
        charger_d = 1'b0;
      end else begin
        charger_d = !sh_q && (tick_q < HalfBits'(pulse_q));
        tick_d    = trk_wrap ? '0 : trk_inc[HalfBits-1:0];
        sh_d      = trk_wrap ? !sh_q : sh_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= ThrReset;
      trickle_q <= TrickleReset;
      end_q     <= EndReset;
      hi_lim_q  <= HiLimReset;
      lo_lim_q  <= LoLimReset;
      pulse_q   <= PulseReset;
      half_q    <= HalfReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FULL_THR:   thr_q     <= cfg_data_i[ThrBits-1:0];
        REG_TRICKLE:    trickle_q <= cfg_data_i[MinBits-1:0];
        REG_END:        end_q     <= cfg_data_i[MinBits-1:0];
        REG_HIGH_LIMIT: hi_lim_q  <= cfg_data_i[LimBits-1:0];
        REG_LOW_LIMIT:  lo_lim_q  <= cfg_data_i[LimBits-1:0];
        REG_PULSE_ON:   pulse_q   <= cfg_data_i[PulseBits-1:0];
        REG_HALF:       half_q    <= cfg_data_i[HalfBits-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tick_q     <= '0;
      sh_q       <= 1'b0;
      blink_q    <= 1'b0;
      green_q    <= 1'b0;
      charger_q  <= 1'b0;
      full_q     <= 1'b0;
      high_run_q <= '0;
      low_run_q  <= '0;
      last_q     <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      sh_q       <= sh_d;
      blink_q    <= blink_d;
      green_q    <= green_d;
      charger_q  <= charger_d;
      full_q     <= full_d;
      high_run_q <= high_run_d;
      low_run_q  <= low_run_d;
      last_q     <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q.charge_on       <= charger_d;
      out_item_q.green_led       <= green_d;
      out_item_q.red_led         <= (phase_d == PH_FAST) || (phase_d == PH_DONE);
      out_item_q.battery_full    <= full_d;
      out_item_q.charge_phase    <= phase_code(phase_d);
      out_item_q.last_voltage_mv <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // red LED tracks fast charge and completion
  a_red_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.red_led == out_item_o.charge_phase[1]))
    else $error("red LED disagrees with phase");

  // a start beat always reports trickle with charger off and full cleared
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.action) |=>
      (out_item_o.charge_phase == PhaseCodeTrickle) && !out_item_o.charge_on &&
      !out_item_o.battery_full)
    else $error("start beat result wrong");

  // complete is sticky under ticks
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_beat && (phase_q == PH_DONE)) |=> (phase_q == PH_DONE))
    else $error("complete phase left on a tick");

  // charger only driven while charging
  a_charger_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.charge_on) |->
      ((out_item_o.charge_phase == PhaseCodeTrickle) ||
       (out_item_o.charge_phase == PhaseCodeFast)))
    else $error("charger on outside a charge phase");

endmodule

`default_nettype wire

### test/charge_sequence_checker.sv
`timescale 1ns / 100ps

module charge_sequence_checker import pfbc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  in_item_t               in_item_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  out_item_t              out_item_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  output int                     errors_o,
  output int                     pending_o
);

  localparam logic [CountBits-1:0] RunMax = '1;

  // register copies
  logic [ThrBits-1:0]   thr_q;
  logic [MinBits-1:0]   trickle_q;
  logic [MinBits-1:0]   end_q;
  logic [LimBits-1:0]   hi_lim_q;
  logic [LimBits-1:0]   lo_lim_q;
  logic [PulseBits-1:0] pulse_q;
  logic [HalfBits-1:0]  half_q;

  // sequencer state
  logic [1:0]           phase_q;
  logic [HalfBits-1:0]  tick_q;
  logic [CountBits-1:0] high_run_q;
  logic [CountBits-1:0] low_run_q;
  logic                 full_q;
  logic                 blink_q;
  logic                 second_q;
  logic                 green_q;
  logic                 charger_q;
  logic [VoltBits-1:0]  last_mv_q;

  out_item_t expected_status_q[$];
  int        miss_cnt;

  function automatic logic [HalfBits-1:0] half_len();
    return (half_q == '0) ? HalfBits'(1) : half_q;
  endfunction

  // qualify one voltage sample into the full flag
  function automatic void check_voltage(logic [VoltBits-1:0] mv);
    logic high;
    high = mv > thr_q;
    last_mv_q = mv;
    if (full_q) begin
      if (high) low_run_q = '0;
      else if (low_run_q < RunMax) low_run_q = low_run_q + 1'b1;
      if (low_run_q > lo_lim_q) begin
        full_q = 1'b0;
        low_run_q = '0;
      end
    end else begin
      if (high) begin
        low_run_q = '0;
        if (high_run_q < RunMax) high_run_q = high_run_q + 1'b1;
      end else begin
        high_run_q = '0;
      end
      if (high_run_q > hi_lim_q) begin
        full_q = 1'b1;
        high_run_q = '0;
      end
    end
  endfunction

  function automatic void fast_tick(logic [VoltBits-1:0] mv, logic [MinBits-1:0] mins);
    if (tick_q == '0) begin
      if (mins < end_q && !full_q) begin
        green_q = blink_q;
        blink_q = !blink_q;
      end else begin
        phase_q = PhaseCodeDone;
        charger_q = 1'b0;
        return;
      end
    end
    charger_q = 1'b1;
    if (tick_q >= half_len() - 1) check_voltage(mv);
    tick_q = tick_q + 1'b1;
    if (tick_q >= half_len()) tick_q = '0;
  endfunction

  function automatic void enter_fast(logic [VoltBits-1:0] mv, logic [MinBits-1:0] mins);
    phase_q = PhaseCodeFast;
    tick_q = '0;
    blink_q = 1'b0;
    fast_tick(mv, mins);
  endfunction

  function automatic void trickle_tick(logic [VoltBits-1:0] mv, logic [MinBits-1:0] mins);
    if (tick_q == '0) begin
      if (!second_q) begin
        if (mins < trickle_q && !full_q) begin
          green_q = 1'b1;
          check_voltage(mv);
          if (full_q) begin
            enter_fast(mv, mins);
            return;
          end
        end else begin
          enter_fast(mv, mins);
          return;
        end
      end else begin
        green_q = 1'b0;
        check_voltage(mv);
      end
    end
    // pulse only in the first half of the period
    charger_q = !second_q && (tick_q < pulse_q);
    tick_q = tick_q + 1'b1;
    if (tick_q >= half_len()) begin
      tick_q = '0;
      second_q = !second_q;
    end
  endfunction

  function automatic out_item_t step_charge(in_item_t beat);
    out_item_t res;
    if (beat.action) begin
      phase_q = PhaseCodeTrickle;
      tick_q = '0;
      second_q = 1'b0;
      full_q = 1'b0;
      last_mv_q = '0;
      charger_q = 1'b0;
    end else if (phase_q == PhaseCodeTrickle) begin
      trickle_tick(beat.voltage_mv, beat.elapsed_minutes);
    end else if (phase_q == PhaseCodeFast) begin
      fast_tick(beat.voltage_mv, beat.elapsed_minutes);
    end
    res.charge_on       = charger_q;
    res.green_led       = green_q;
    res.red_led         = phase_q >= PhaseCodeFast;
    res.battery_full    = full_q;
    res.charge_phase    = phase_q;
    res.last_voltage_mv = last_mv_q;
    return res;
  endfunction

  function automatic void write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
    case (cfg_reg_e'(idx))
      REG_FULL_THR:   thr_q = data[ThrBits-1:0];
      REG_TRICKLE:    trickle_q = data[MinBits-1:0];
      REG_END:        end_q = data[MinBits-1:0];
      REG_HIGH_LIMIT: hi_lim_q = data[LimBits-1:0];
      REG_LOW_LIMIT:  lo_lim_q = data[LimBits-1:0];
      REG_PULSE_ON:   pulse_q = data[PulseBits-1:0];
      REG_HALF:       half_q = data[HalfBits-1:0];
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      thr_q = ThrReset;
      trickle_q = TrickleReset;
      end_q = EndReset;
      hi_lim_q = HiLimReset;
      lo_lim_q = LoLimReset;
      pulse_q = PulseReset;
      half_q = HalfReset;
      phase_q = PhaseCodeIdle;
      tick_q = '0;
      high_run_q = '0;
      low_run_q = '0;
      full_q = 1'b0;
      blink_q = 1'b0;
      second_q = 1'b0;
      green_q = 1'b0;
      charger_q = 1'b0;
      last_mv_q = '0;
      expected_status_q.delete();
      miss_cnt = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_reg(cfg_index_i, cfg_data_i);
      // retire before predicting: a result never leaves in its own input cycle
      if (out_valid_i && out_ready_i) begin
        if (expected_status_q.size() == 0) begin
          if (miss_cnt < 10) begin
            $write("%0t: status beat with none expected:", $realtime);
            $display(" on=%0b grn=%0b red=%0b full=%0b ph=%0d mv=%0d",
                     out_item_i.charge_on, out_item_i.green_led, out_item_i.red_led,
                     out_item_i.battery_full, out_item_i.charge_phase,
                     out_item_i.last_voltage_mv);
          end
          miss_cnt++;
        end else begin
          want = expected_status_q.pop_front();
          if (out_item_i.charge_on !== want.charge_on ||
              out_item_i.green_led !== want.green_led ||
              out_item_i.red_led !== want.red_led ||
              out_item_i.battery_full !== want.battery_full ||
              out_item_i.charge_phase !== want.charge_phase ||
              out_item_i.last_voltage_mv !== want.last_voltage_mv) begin
            if (miss_cnt < 10) begin
              $write("%0t: status mismatch: want on=%0b grn=%0b red=%0b full=%0b",
                     $realtime, want.charge_on, want.green_led, want.red_led,
                     want.battery_full);
              $write(" ph=%0d mv=%0d,", want.charge_phase, want.last_voltage_mv);
              $display(" got on=%0b grn=%0b red=%0b full=%0b ph=%0d mv=%0d",
                       out_item_i.charge_on, out_item_i.green_led, out_item_i.red_led,
                       out_item_i.battery_full, out_item_i.charge_phase,
                       out_item_i.last_voltage_mv);
            end
            miss_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_status_q.push_back(step_charge(in_item_i));
      errors_o <= miss_cnt;
      pending_o <= expected_status_q.size();
    end
  end

endmodule

### test/pulse_then_fast_battery_charger_unit_test.sv
`timescale 1ns / 100ps

module pulse_then_fast_battery_charger_unit_test;
  import pfbc_pkg::*;

  localparam logic                  ActTick      = 1'b0;
  localparam logic                  ActStart     = 1'b1;
  localparam logic [CfgIdxBits-1:0] CfgIdxUnused = 3'd7;
  localparam int unsigned           VoltMax      = (1 << VoltBits) - 1;
  localparam int unsigned           DataMax      = (1 << CfgDataBits) - 1;
  localparam int unsigned           CycleLimit   = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_item = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxBits-1:0]  cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;

  int errors;
  int pending;

  int unsigned cycle_cnt = 0;
  int unsigned stall_cnt = 0;
  int unsigned sent = 0;
  bit          calm = 1'b0;

  // shaping copies of the current settings
  logic [ThrBits-1:0] cur_thr = ThrReset;
  logic [MinBits-1:0] cur_trk = TrickleReset;

  pulse_then_fast_battery_charger_unit u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  charge_sequence_checker u_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_item_i (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    int unsigned n;
    if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      n = calm ? 0 : idle_len();
      out_ready <= (n == 0);
      if (n != 0) stall_cnt <= n - 1;
    end
  end

  task automatic send_item(logic act, logic [VoltBits-1:0] mv, logic [MinBits-1:0] mins);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= '{action: act, voltage_mv: mv, elapsed_minutes: mins};
    do @(posedge clk); while (!in_ready);
    sent++;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(logic [CfgDataBits-1:0] thr, logic [CfgDataBits-1:0] trk,
                              logic [CfgDataBits-1:0] endm, logic [CfgDataBits-1:0] hi,
                              logic [CfgDataBits-1:0] lo, logic [CfgDataBits-1:0] pls,
                              logic [CfgDataBits-1:0] half);
    drain();
    // spare clock edges after the drain before writing the registers
    repeat (2) @(posedge clk);
    cfg_write(REG_FULL_THR, thr);
    cfg_write(REG_TRICKLE, trk);
    cfg_write(REG_END, endm);
    cfg_write(REG_HIGH_LIMIT, hi);
    cfg_write(REG_LOW_LIMIT, lo);
    cfg_write(REG_PULSE_ON, pls);
    cfg_write(REG_HALF, half);
    cur_thr = thr[ThrBits-1:0];
    cur_trk = trk[MinBits-1:0];
  endtask

  function automatic logic [VoltBits-1:0] pick_volt(bit high_lvl);
    if (!high_lvl) return VoltBits'($urandom_range(0, cur_thr));
    if (cur_thr == '1) return '1;
    return VoltBits'($urandom_range(cur_thr + 1, VoltMax));
  endfunction

  // start, then a run of ticks with rising minutes and level-shaped voltages, with a rare random beat mixed in
  task automatic run_sequence();
    int unsigned len;
    int unsigned mode;
    int unsigned r;
    int          mins;
    bit          lvl;
    len = $urandom_range(4, 80);
    mode = $urandom_range(0, 2);
    lvl = (mode == 1);
    mins = $urandom_range(0, cur_trk);
    calm = ($urandom_range(0, 3) == 0);
    send_item(ActStart, VoltBits'($urandom), MinBits'($urandom));
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (r == 9) mins = mins + $urandom_range(1, 20);
      else if (r >= 6) mins = mins + 1;
      if (mins > 255) mins = 255;
      if (mode == 2 && $urandom_range(0, 4) == 0) lvl = !lvl;
      if ($urandom_range(0, 24) == 0)
        send_item(logic'($urandom_range(0, 1)), VoltBits'($urandom), MinBits'($urandom));
      else
        send_item(ActTick, pick_volt(lvl), MinBits'(mins));
    end
    calm = 1'b0;
    if ($urandom_range(0, 7) == 0) drain();
  endtask

  task automatic random_run(int unsigned quota);
    int unsigned target;
    target = sent + quota;
    while (sent < target) run_sequence();
  endtask

  function automatic logic [CfgDataBits-1:0] with_junk(int unsigned val, int unsigned width);
    return CfgDataBits'(($urandom_range(0, DataMax) >> width << width) | val);
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults out of reset
    random_run(120);

    // fast periods so the whole sequence fits in a few beats
    program_regs(8000, 2, 4, 1, 1, 1, 1);
    cfg_write(CfgIdxUnused, CfgDataBits'($urandom_range(0, DataMax)));
    send_item(ActTick, 16383, 255);    // tick before the start, in whatever phase the random run left
    send_item(ActStart, 0, 0);
    send_item(ActTick, 0, 0);
    send_item(ActTick, 16383, 0);
    send_item(ActTick, 16383, 0);      // full at period start: fast then done
    send_item(ActTick, 0, 0);          // done: ignored
    send_item(ActStart, 16383, 255);
    send_item(ActTick, 0, 0);
    send_item(ActTick, 0, 1);
    send_item(ActTick, 100, 2);        // trickle minute reached
    send_item(ActTick, 9000, 2);
    send_item(ActTick, 9000, 2);
    send_item(ActTick, 9000, 3);
    send_item(ActStart, 0, 0);
    send_item(ActTick, 0, 2);
    send_item(ActTick, 0, 3);
    send_item(ActStart, 0, 3);         // restart from fast
    send_item(ActTick, 0, 5);          // past end minute at once

    // zero half period, pulse wider than the half, limits at saturation
    program_regs(0, 255, 255, 15, 15, 31, 0);
    send_item(ActStart, 0, 0);
    for (int i = 0; i < 6; i++) send_item(ActTick, VoltBits'(i), 8'd10);

    program_regs(0, 0, 0, 0, 0, 0, 0);
    random_run(60);

    program_regs(DataMax, 255, 255, 15, 15, 31, 63);
    random_run(100);

    for (int p = 0; p < 4; p++) begin
      program_regs(CfgDataBits'($urandom_range(0, DataMax)),
                   with_junk($urandom_range(0, 10), MinBits),
                   with_junk($urandom_range(0, 30), MinBits),
                   CfgDataBits'($urandom_range(0, DataMax)),
                   CfgDataBits'($urandom_range(0, DataMax)),
                   CfgDataBits'($urandom_range(0, DataMax)),
                   with_junk($urandom_range(0, 4), HalfBits));
      random_run(170);
    end

    drain();
    repeat (4) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
